@@ hw/rtl/ktd_pkg.sv @@
// Shared types, field widths and codes of the keyword trie automaton.
package ktd_pkg;

   // Default sizes of the automaton.
   localparam int DEF_NUM_STATES  = 512;
   localparam int DEF_NUM_SYMBOLS = 256;
   localparam int DEF_MAX_TOKENS  = 64;
   localparam int DEF_QUEUE_DEPTH = 2;

   // Field widths of the item formats.
   localparam int ACTION_W = 2;
   localparam int SYMBOL_W = 8;
   localparam int TOKEN_W  = 6;
   localparam int QSTATE_W = 9;
   localparam int STATUS_W = 2;

   localparam int REQ_TDATA_W = 24;
   localparam int REQ_TUSER_W = ACTION_W;
   localparam int RSP_FIELD_W = QSTATE_W + 1 + TOKEN_W + 1 + STATUS_W;
   localparam int RSP_TDATA_W = 24;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_FIELD_W;

   typedef logic [ACTION_W-1:0] action_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [2:0]          op_type;

   // Request actions.
   localparam action_type ACT_BUILD = 2'd0;
   localparam action_type ACT_END   = 2'd1;
   localparam action_type ACT_EVAL  = 2'd2;

   // Result status codes.
   localparam status_type STS_OK    = 2'd0;
   localparam status_type STS_FULL  = 2'd1;
   localparam status_type STS_RANGE = 2'd2;
   localparam status_type STS_ZERO  = 2'd3;

   // Operations handed from the front end to the execution side.
   localparam op_type OP_BUILD       = 3'd0;
   localparam op_type OP_END         = 3'd1;
   localparam op_type OP_EVAL        = 3'd2;
   localparam op_type OP_EVAL_BADSYM = 3'd3;
   localparam op_type OP_CUR_ERR     = 3'd4;
   localparam op_type OP_BAD         = 3'd5;

   typedef struct packed {
      op_type                op;
      status_type            status;
      logic [SYMBOL_W-1:0]   symbol;
      logic [TOKEN_W-1:0]    token_id;
      logic [QSTATE_W-1:0]   query_state;
   } queue_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

endpackage

@@ hw/rtl/ktd_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module ktd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/ktd_front.sv @@
// Front end: takes request items, checks their fields and classifies them.
module ktd_front #(
   parameter int NUM_SYMBOLS = 256,
   parameter int MAX_TOKENS  = 64
) (
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ktd_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic [ktd_pkg::REQ_TUSER_W-1:0]   req_tuser,
   input  ktd_pkg::back_status_type          back_status,
   input  ktd_pkg::queue_status_type         queue_status,
   output logic                              push,
   output ktd_pkg::queue_item_type           push_item
);
   import ktd_pkg::*;

   logic [SYMBOL_W-1:0] symbol;
   logic [TOKEN_W-1:0]  token_id;
   logic [QSTATE_W-1:0] query_state;
   logic                sym_bad;
   logic                tok_bad;

   assign symbol      = req_tdata[SYMBOL_W-1:0];
   assign token_id    = req_tdata[SYMBOL_W+TOKEN_W-1:SYMBOL_W];
   assign query_state = req_tdata[SYMBOL_W+TOKEN_W+QSTATE_W-1:SYMBOL_W+TOKEN_W];

   assign sym_bad = 32'(symbol) >= 32'(NUM_SYMBOLS);
   assign tok_bad = 32'(token_id) >= 32'(MAX_TOKENS);

   assign req_tready = !queue_status.full && !back_status.clearing;
   assign push       = req_tvalid && req_tready;

   always_comb begin
      push_item.status      = STS_OK;
      push_item.symbol      = symbol;
      push_item.token_id    = token_id;
      push_item.query_state = query_state;
      unique case (req_tuser)
         ACT_BUILD: begin
            if (symbol == '0) begin
               push_item.op     = OP_CUR_ERR;
               push_item.status = STS_ZERO;
            end else if (sym_bad) begin
               push_item.op     = OP_CUR_ERR;
               push_item.status = STS_RANGE;
            end else begin
               push_item.op = OP_BUILD;
            end
         end
         ACT_END: begin
            if (tok_bad) begin
               push_item.op     = OP_CUR_ERR;
               push_item.status = STS_RANGE;
            end else begin
               push_item.op = OP_END;
            end
         end
         ACT_EVAL: begin
            push_item.op = sym_bad ? OP_EVAL_BADSYM : OP_EVAL;
         end
         default: begin
            push_item.op = OP_BAD;
         end
      endcase
   end

endmodule

@@ hw/rtl/ktd_queue.sv @@
// Short FIFO that carries classified items from the front end to the back end.
module ktd_queue #(
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  ktd_pkg::queue_item_type    push_item,
   input  logic                       pop,
   output ktd_pkg::queue_item_type    head_item,
   output ktd_pkg::queue_status_type  queue_status
);
   import ktd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   queue_item_type    entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item          = entry_ff[rd_ptr_ff];
   assign queue_status.full  = count_ff == CNT_W'(DEPTH);
   assign queue_status.empty = count_ff == '0;

endmodule

@@ hw/rtl/ktd_back.sv @@
// Back end: owns the transition and token stores and carries out each item.
module ktd_back #(
   parameter int NUM_STATES  = 512,
   parameter int NUM_SYMBOLS = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ktd_pkg::queue_item_type           head_item,
   input  ktd_pkg::queue_status_type         queue_status,
   output logic                              pop,
   output ktd_pkg::back_status_type          back_status,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ktd_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import ktd_pkg::*;

   localparam int ST_W    = $clog2(NUM_STATES);
   localparam int SYM_W   = $clog2(NUM_SYMBOLS);
   localparam int ADDR_W  = ST_W + SYM_W;
   localparam int T_DEPTH = NUM_STATES << SYM_W;
   localparam int T_W     = ST_W + 1;
   localparam int TOK_E_W = TOKEN_W + 1;

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_EXEC  = 2'd2;
   localparam logic [1:0] S_LOOP  = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [ADDR_W-1:0]   clr_ff, clr_in;
   queue_item_type      item_ff, item_in;
   logic [ST_W-1:0]     cursor_ff, cursor_in;
   logic [ST_W:0]       nf_ff, nf_in;
   logic [ST_W-1:0]     target_ff, target_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [QSTATE_W-1:0] rsp_ns_ff;
   logic                rsp_nv_ff;
   logic [TOKEN_W-1:0]  rsp_tok_ff;
   logic                rsp_term_ff;
   status_type          rsp_status_ff;

   logic                t_wr_en, t_rd_en;
   logic [ADDR_W-1:0]   t_wr_addr, t_rd_addr;
   logic [T_W-1:0]      t_wr_data, t_rd_data;
   logic                tok_wr_en, tok_rd_en;
   logic [ST_W-1:0]     tok_wr_addr, tok_rd_addr;
   logic [TOK_E_W-1:0]  tok_wr_data, tok_rd_data;

   logic                can_out;
   logic                head_is_eval;
   logic [ST_W-1:0]     head_state;
   logic                t_valid;
   logic [ST_W-1:0]     t_target;
   logic                tok_valid;
   logic [TOKEN_W-1:0]  tok_value;
   logic                table_full;
   logic                qs_bad;

   logic                res_load;
   logic [ST_W-1:0]     res_ns;
   logic                res_nv;
   logic [TOKEN_W-1:0]  res_tok;
   logic                res_term;
   status_type          res_status;

   ktd_ram #(
      .WIDTH (T_W),
      .DEPTH (T_DEPTH)
   ) u_trans_ram (
      .clock   (clock),
      .wr_en   (t_wr_en),
      .wr_addr (t_wr_addr),
      .wr_data (t_wr_data),
      .rd_en   (t_rd_en),
      .rd_addr (t_rd_addr),
      .rd_data (t_rd_data)
   );

   ktd_ram #(
      .WIDTH (TOK_E_W),
      .DEPTH (NUM_STATES)
   ) u_token_ram (
      .clock   (clock),
      .wr_en   (tok_wr_en),
      .wr_addr (tok_wr_addr),
      .wr_data (tok_wr_data),
      .rd_en   (tok_rd_en),
      .rd_addr (tok_rd_addr),
      .rd_data (tok_rd_data)
   );

   assign can_out      = !rsp_valid_ff || rsp_tready;
   assign head_is_eval = (head_item.op == OP_EVAL) || (head_item.op == OP_EVAL_BADSYM);
   assign head_state   = head_is_eval ? ST_W'(head_item.query_state) : cursor_ff;
   assign t_valid      = t_rd_data[ST_W];
   assign t_target     = t_rd_data[ST_W-1:0];
   assign tok_valid    = tok_rd_data[TOKEN_W];
   assign tok_value    = tok_valid ? tok_rd_data[TOKEN_W-1:0] : '0;
   assign table_full   = nf_ff == (ST_W+1)'(NUM_STATES);
   assign qs_bad       = 32'(item_ff.query_state) >= 32'(nf_ff);

   assign back_status.clearing = state_ff == S_CLEAR;

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      item_in     = item_ff;
      cursor_in   = cursor_ff;
      nf_in       = nf_ff;
      target_in   = target_ff;
      pop         = 1'b0;

      t_wr_en     = 1'b0;
      t_wr_addr   = {cursor_ff, {SYM_W{1'b0}}};
      t_wr_data   = {1'b1, cursor_ff};
      t_rd_en     = 1'b0;
      t_rd_addr   = {head_state, SYM_W'(head_item.symbol)};
      tok_wr_en   = 1'b0;
      tok_wr_addr = cursor_ff;
      tok_wr_data = {1'b1, item_ff.token_id};
      tok_rd_en   = 1'b0;
      tok_rd_addr = head_state;

      res_load    = 1'b0;
      res_ns      = '0;
      res_nv      = 1'b0;
      res_tok     = '0;
      res_term    = 1'b0;
      res_status  = STS_RANGE;

      unique case (state_ff)
         S_CLEAR: begin
            // One transition entry per cycle; the token store rides along.
            t_wr_en     = 1'b1;
            t_wr_addr   = clr_ff;
            t_wr_data   = '0;
            tok_wr_en   = 32'(clr_ff) < 32'(NUM_STATES);
            tok_wr_addr = clr_ff[ST_W-1:0];
            tok_wr_data = '0;
            clr_in      = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(T_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (!queue_status.empty) begin
               pop       = 1'b1;
               item_in   = head_item;
               t_rd_en   = 1'b1;
               tok_rd_en = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (item_ff.op)
               OP_BUILD: begin
                  if (t_valid) begin
                     target_in   = t_target;
                     tok_rd_en   = 1'b1;
                     tok_rd_addr = t_target;
                     state_in    = S_LOOP;
                  end else if (table_full) begin
                     if (can_out) begin
                        res_load   = 1'b1;
                        res_ns     = cursor_ff;
                        res_tok    = tok_value;
                        res_term   = tok_valid;
                        res_status = STS_FULL;
                        state_in   = S_IDLE;
                     end
                  end else begin
                     // Allocate the next free state for this edge.
                     t_wr_en     = 1'b1;
                     t_wr_addr   = {cursor_ff, SYM_W'(item_ff.symbol)};
                     t_wr_data   = {1'b1, nf_ff[ST_W-1:0]};
                     nf_in       = nf_ff + (ST_W+1)'(1);
                     target_in   = nf_ff[ST_W-1:0];
                     tok_rd_en   = 1'b1;
                     tok_rd_addr = nf_ff[ST_W-1:0];
                     state_in    = S_LOOP;
                  end
               end
               OP_END: begin
                  if (can_out) begin
                     t_wr_en    = 1'b1;
                     tok_wr_en  = 1'b1;
                     cursor_in  = '0;
                     res_load   = 1'b1;
                     res_ns     = '0;
                     res_nv     = 1'b1;
                     res_tok    = item_ff.token_id;
                     res_term   = 1'b1;
                     res_status = STS_OK;
                     state_in   = S_IDLE;
                  end
               end
               OP_EVAL: begin
                  if (can_out) begin
                     res_load = 1'b1;
                     state_in = S_IDLE;
                     if (!qs_bad) begin
                        res_ns     = t_valid ? t_target : '0;
                        res_nv     = t_valid;
                        res_tok    = tok_value;
                        res_term   = tok_valid;
                        res_status = STS_OK;
                     end
                  end
               end
               OP_EVAL_BADSYM: begin
                  if (can_out) begin
                     res_load = 1'b1;
                     state_in = S_IDLE;
                     if (!qs_bad) begin
                        res_tok  = tok_value;
                        res_term = tok_valid;
                     end
                  end
               end
               OP_CUR_ERR: begin
                  if (can_out) begin
                     res_load   = 1'b1;
                     res_ns     = cursor_ff;
                     res_tok    = tok_value;
                     res_term   = tok_valid;
                     res_status = item_ff.status;
                     state_in   = S_IDLE;
                  end
               end
               default: begin
                  if (can_out) begin
                     res_load = 1'b1;
                     state_in = S_IDLE;
                  end
               end
            endcase
         end
         S_LOOP: begin
            // Self-loop on symbol zero for the state the step started from.
            if (can_out) begin
               t_wr_en    = 1'b1;
               cursor_in  = target_ff;
               res_load   = 1'b1;
               res_ns     = target_ff;
               res_nv     = 1'b1;
               res_tok    = tok_value;
               res_term   = tok_valid;
               res_status = STS_OK;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase

      rsp_valid_in = res_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         cursor_ff    <= '0;
         nf_ff        <= (ST_W+1)'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cursor_ff    <= cursor_in;
         nf_ff        <= nf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      target_ff <= target_in;
      if (res_load) begin
         rsp_ns_ff     <= QSTATE_W'(res_ns);
         rsp_nv_ff     <= res_nv;
         rsp_tok_ff    <= res_tok;
         rsp_term_ff   <= res_term;
         rsp_status_ff <= res_status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_status_ff, rsp_term_ff, rsp_tok_ff,
                        rsp_nv_ff, rsp_ns_ff};

endmodule

@@ hw/rtl/keyword_trie_dfa.sv @@
// Top level of the keyword trie automaton: front end, item queue and back end.
//
//   channel   dir   handshake                tdata / tuser
//   req_      in    req_tvalid / req_tready  tdata: symbol, token_id, query_state
//                                            tuser: action
//   rsp_      out   rsp_tvalid / rsp_tready  tdata: next_state, next_valid,
//                                            state_token, is_terminal, status
//
// In the back end an item moves from S_IDLE (store read) to S_EXEC (result); a
// build character that follows or allocates an edge also passes S_LOOP, as the
// transition store has one write port and the self-loop write needs its own state.
// After reset the back end clears the stores, one transition entry per cycle, over
// all NUM_STATES * 2**ceil(log2(NUM_SYMBOLS)) entries (131072 by default); no item is
// taken meanwhile. The queue lets requests arrive while the result register waits.
module keyword_trie_dfa #(
   parameter int NUM_STATES  = ktd_pkg::DEF_NUM_STATES,
   parameter int NUM_SYMBOLS = ktd_pkg::DEF_NUM_SYMBOLS,
   parameter int MAX_TOKENS  = ktd_pkg::DEF_MAX_TOKENS,
   parameter int QUEUE_DEPTH = ktd_pkg::DEF_QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // symbol[7:0], token_id[13:8], query_state[22:14], zero[23]
   input  logic [ktd_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // action[1:0]
   input  logic [ktd_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // next_state[8:0], next_valid[9], state_token[15:10], is_terminal[16],
   // status[18:17], zero[23:19]
   output logic [ktd_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import ktd_pkg::*;

   queue_item_type    push_item;
   queue_item_type    head_item;
   queue_status_type  queue_status;
   back_status_type   back_status;
   logic              push;
   logic              pop;

   ktd_front #(
      .NUM_SYMBOLS (NUM_SYMBOLS),
      .MAX_TOKENS  (MAX_TOKENS)
   ) u_front (
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .back_status  (back_status),
      .queue_status (queue_status),
      .push         (push),
      .push_item    (push_item)
   );

   ktd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_item    (push_item),
      .pop          (pop),
      .head_item    (head_item),
      .queue_status (queue_status)
   );

   ktd_back #(
      .NUM_STATES  (NUM_STATES),
      .NUM_SYMBOLS (NUM_SYMBOLS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head_item    (head_item),
      .queue_status (queue_status),
      .pop          (pop),
      .back_status  (back_status),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

endmodule

@@ tb/keyword_trie_dfa_tb.sv @@
// Self-checking testbench for the keyword trie automaton: random keywords, lookups and noise.
module keyword_trie_dfa_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ktd_pkg::*;

   localparam int NSTATES      = DEF_NUM_STATES;
   localparam int NSYMBOLS     = DEF_NUM_SYMBOLS;
   localparam int NTOKENS      = DEF_MAX_TOKENS;
   localparam int ITEM_TARGET  = 1200;
   localparam int KW_SLOTS     = 32;
   localparam int KW_MAX       = 10;
   localparam int DRAIN_CYCLES = 40;
   // The limit also covers the clearing pass after reset.
   localparam int CYCLE_LIMIT  = 1000000;

   // Action code that the block does not define.
   localparam action_type ACT_UNDEF = 2'd3;

   typedef struct {
      logic [QSTATE_W-1:0] next_state;
      logic                next_valid;
      logic [TOKEN_W-1:0]  state_token;
      logic                is_terminal;
      status_type          status;
   } trie_result_type;

   class trie_scoreboard_type;
      // A present key (state * NSYMBOLS + symbol) is a transition to the stored state.
      logic [QSTATE_W-1:0] trans_target [int];
      bit                  tok_valid [NSTATES];
      bit [TOKEN_W-1:0]    tok_value [NSTATES];
      logic [QSTATE_W-1:0] cursor;
      int                  next_free;
      trie_result_type     awaited [$];
      int                  errors;
      int                  checked;
      int                  status_seen [4];

      function new();
         cursor    = '0;
         next_free = 1;
         errors    = 0;
         checked   = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function trie_result_type result_for(logic [QSTATE_W-1:0] ns, logic nv, int st,
                                           status_type sts);
         trie_result_type r;
         r.next_state  = ns;
         r.next_valid  = nv;
         r.state_token = '0;
         r.is_terminal = 1'b0;
         r.status      = sts;
         if (st < NSTATES && tok_valid[st]) begin
            r.is_terminal = 1'b1;
            r.state_token = tok_value[st];
         end
         return r;
      endfunction

      function void note_request(action_type act, logic [REQ_TDATA_W-1:0] data);
         logic [SYMBOL_W-1:0] sym;
         logic [TOKEN_W-1:0]  tid;
         logic [QSTATE_W-1:0] qs;
         int                  key;
         trie_result_type     r;
         sym = data[7:0];
         tid = data[13:8];
         qs  = data[22:14];
         r   = result_for('0, 1'b0, NSTATES, STS_RANGE);
         key = int'(cursor) * NSYMBOLS + int'(sym);
         case (act)
            ACT_BUILD: begin
               if (sym == '0) begin
                  r = result_for(cursor, 1'b0, cursor, STS_ZERO);
               end else if (int'(sym) >= NSYMBOLS) begin
                  r = result_for(cursor, 1'b0, cursor, STS_RANGE);
               end else if (!trans_target.exists(key) && next_free >= NSTATES) begin
                  r = result_for(cursor, 1'b0, cursor, STS_FULL);
               end else begin
                  if (!trans_target.exists(key)) begin
                     trans_target[key] = QSTATE_W'(next_free);
                     next_free++;
                  end
                  trans_target[int'(cursor) * NSYMBOLS] = cursor;
                  cursor = trans_target[key];
                  r = result_for(cursor, 1'b1, cursor, STS_OK);
               end
            end
            ACT_END: begin
               if (int'(tid) >= NTOKENS) begin
                  r = result_for(cursor, 1'b0, cursor, STS_RANGE);
               end else begin
                  trans_target[int'(cursor) * NSYMBOLS] = cursor;
                  tok_valid[cursor] = 1'b1;
                  tok_value[cursor] = tid;
                  r = result_for('0, 1'b1, cursor, STS_OK);
                  cursor = '0;
               end
            end
            ACT_EVAL: begin
               key = int'(qs) * NSYMBOLS + int'(sym);
               if (int'(qs) >= next_free)
                  r = result_for('0, 1'b0, NSTATES, STS_RANGE);
               else if (int'(sym) >= NSYMBOLS)
                  r = result_for('0, 1'b0, qs, STS_RANGE);
               else if (trans_target.exists(key))
                  r = result_for(trans_target[key], 1'b1, qs, STS_OK);
               else
                  r = result_for('0, 1'b0, qs, STS_OK);
            end
            default: ;
         endcase
         status_seen[r.status]++;
         awaited.push_back(r);
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         errors++;
         if (errors <= 40)
            $display("Mismatch at result %0d: %s is %0d, expected %0d",
                     checked, what, got, want);
      endtask

      task check_result(logic [RSP_TDATA_W-1:0] data);
         trie_result_type want;
         if (awaited.size() == 0) begin
            report_mismatch("unexpected result, tdata", 32'(data), 0);
            return;
         end
         want = awaited.pop_front();
         if (data[8:0] !== want.next_state)
            report_mismatch("next_state", 32'(data[8:0]), 32'(want.next_state));
         if (data[9] !== want.next_valid)
            report_mismatch("next_valid", 32'(data[9]), 32'(want.next_valid));
         if (data[15:10] !== want.state_token)
            report_mismatch("state_token", 32'(data[15:10]), 32'(want.state_token));
         if (data[16] !== want.is_terminal)
            report_mismatch("is_terminal", 32'(data[16]), 32'(want.is_terminal));
         if (data[18:17] !== want.status)
            report_mismatch("status", 32'(data[18:17]), 32'(want.status));
         checked++;
      endtask
   endclass

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   trie_scoreboard_type sb;
   int          items_sent  = 0;
   int          req_calm    = 0;
   int          rsp_calm    = 0;
   int unsigned cycle_count = 0;

   keyword_trie_dfa dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Run exceeded %0d cycles", CYCLE_LIMIT);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Cycles to wait before the next item; now and then a calm stretch with no waiting.
   function automatic int draw_wait(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 15);
   endfunction

   task automatic send_item(action_type act, logic [SYMBOL_W-1:0] sym,
                            logic [TOKEN_W-1:0] tid, logic [QSTATE_W-1:0] qs);
      int gap;
      gap = draw_wait(req_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {1'b0, qs, tid, sym};
      do @(posedge clock); while (!req_tready);
      sb.note_request(act, {1'b0, qs, tid, sym});
      items_sent++;
   endtask

   task automatic take_results();
      int stall;
      forever begin
         stall = draw_wait(rsp_calm);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_result(rsp_tdata);
      end
   endtask

   initial begin
      logic [SYMBOL_W-1:0] kw_store [KW_SLOTS][KW_MAX];
      int                  kw_len [KW_SLOTS];
      logic [SYMBOL_W-1:0] cur_kw [KW_MAX];
      int                  kw_count;
      int                  len;
      int                  slot;
      int                  pick;
      logic [QSTATE_W-1:0] qs;
      logic [SYMBOL_W-1:0] sym;

      sb       = new();
      kw_count = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      fork
         take_results();
      join_none

      // Lookups on the empty automaton, an unknown action, an empty keyword and a zero symbol.
      send_item(ACT_EVAL, 8'd0, 6'd0, 9'd0);
      send_item(ACT_EVAL, 8'd255, 6'd63, 9'd511);
      send_item(ACT_EVAL, 8'd1, 6'd0, 9'd1);
      send_item(ACT_UNDEF, 8'd255, 6'd63, 9'd511);
      send_item(ACT_END, 8'd0, 6'd0, 9'd0);
      send_item(ACT_BUILD, 8'd0, 6'd63, 9'd511);
      // A keyword, a longer one sharing its prefix, then the first again with a new token.
      send_item(ACT_BUILD, 8'd255, 6'd0, 9'd0);
      send_item(ACT_BUILD, 8'd1, 6'd0, 9'd0);
      send_item(ACT_END, 8'd0, 6'd63, 9'd0);
      send_item(ACT_BUILD, 8'd255, 6'd0, 9'd0);
      send_item(ACT_BUILD, 8'd1, 6'd0, 9'd0);
      send_item(ACT_BUILD, 8'd2, 6'd0, 9'd0);
      send_item(ACT_END, 8'd0, 6'd5, 9'd0);
      send_item(ACT_BUILD, 8'd255, 6'd0, 9'd0);
      send_item(ACT_BUILD, 8'd1, 6'd0, 9'd0);
      send_item(ACT_END, 8'd0, 6'd42, 9'd0);
      send_item(ACT_EVAL, 8'd255, 6'd0, 9'd0);
      send_item(ACT_EVAL, 8'd0, 6'd0, 9'd1);
      send_item(ACT_EVAL, 8'd2, 6'd0, 9'd2);
      send_item(ACT_EVAL, 8'd0, 6'd0, 9'd3);
      send_item(ACT_EVAL, 8'd0, 6'd0, 9'd0);
      // A zero symbol in the middle of a keyword leaves the cursor where it is.
      send_item(ACT_BUILD, 8'd7, 6'd0, 9'd0);
      send_item(ACT_BUILD, 8'd0, 6'd0, 9'd0);
      send_item(ACT_END, 8'd0, 6'd1, 9'd0);

      // Mostly whole keywords, so that the store fills and the full case is hit.
      while (items_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            if (kw_count > 0 && $urandom_range(0, 9) == 0) begin
               slot = $urandom_range(0, ((kw_count < KW_SLOTS) ? kw_count : KW_SLOTS) - 1);
               len  = kw_len[slot];
               for (int i = 0; i < len; i++) cur_kw[i] = kw_store[slot][i];
            end else begin
               len  = $urandom_range(1, KW_MAX);
               slot = kw_count % KW_SLOTS;
               for (int i = 0; i < len; i++) begin
                  cur_kw[i] = ($urandom_range(0, 3) == 0) ? SYMBOL_W'($urandom_range(1, 6))
                                                          : SYMBOL_W'($urandom_range(1, 255));
                  kw_store[slot][i] = cur_kw[i];
               end
               kw_len[slot] = len;
               kw_count++;
            end
            for (int i = 0; i < len; i++)
               send_item(ACT_BUILD, cur_kw[i], TOKEN_W'($urandom_range(0, 63)),
                         QSTATE_W'($urandom_range(0, 511)));
            send_item(ACT_END, SYMBOL_W'($urandom_range(0, 255)),
                      TOKEN_W'($urandom_range(0, 63)), QSTATE_W'($urandom_range(0, 511)));
         end else if (pick < 88) begin
            if (sb.next_free < NSTATES && $urandom_range(0, 7) == 0)
               qs = QSTATE_W'($urandom_range(sb.next_free, NSTATES - 1));
            else
               qs = QSTATE_W'($urandom_range(0, sb.next_free - 1));
            case ($urandom_range(0, 3))
               0:       sym = '0;
               1:       sym = SYMBOL_W'($urandom_range(1, 6));
               default: sym = SYMBOL_W'($urandom_range(0, 255));
            endcase
            send_item(ACT_EVAL, sym, TOKEN_W'($urandom_range(0, 63)), qs);
         end else begin
            case ($urandom_range(0, 3))
               0: send_item(ACT_BUILD, 8'd0, TOKEN_W'($urandom_range(0, 63)),
                            QSTATE_W'($urandom_range(0, 511)));
               1: send_item(ACT_UNDEF, SYMBOL_W'($urandom_range(0, 255)),
                            TOKEN_W'($urandom_range(0, 63)),
                            QSTATE_W'($urandom_range(0, 511)));
               2: send_item(ACT_END, SYMBOL_W'($urandom_range(0, 255)),
                            TOKEN_W'($urandom_range(0, 63)),
                            QSTATE_W'($urandom_range(0, 511)));
               default: begin
                  // Broken keyword: a few characters and no end item.
                  len = $urandom_range(1, 3);
                  for (int i = 0; i < len; i++)
                     send_item(ACT_BUILD, SYMBOL_W'($urandom_range(1, 255)),
                               TOKEN_W'($urandom_range(0, 63)),
                               QSTATE_W'($urandom_range(0, 511)));
               end
            endcase
         end
      end
      req_tvalid <= 1'b0;

      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d items, checked %0d results, %0d of %0d states in use.",
               items_sent, sb.checked, sb.next_free, NSTATES);
      $display("Statuses seen: ok %0d, table full %0d, out of range %0d, zero symbol %0d.",
               sb.status_seen[STS_OK], sb.status_seen[STS_FULL],
               sb.status_seen[STS_RANGE], sb.status_seen[STS_ZERO]);
      if (sb.errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/ktd_pkg.sv
hw/rtl/ktd_ram.sv
hw/rtl/ktd_front.sv
hw/rtl/ktd_queue.sv
hw/rtl/ktd_back.sv
hw/rtl/keyword_trie_dfa.sv
tb/keyword_trie_dfa_tb.sv
